/* design/mft_pkg.sv */
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants of the Manchester frame transmitter: payload
// structs of both channels, configuration bundle, register indexes and resets.
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CODE_W      = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] RST_HALF_BIT = 16'd3;
    localparam logic [CFG_DATA_W-1:0] RST_HEADER   = 16'd6;
    localparam logic [CFG_DATA_W-1:0] RST_GAP      = 16'd40;

    typedef struct packed {
        logic              command;
        logic [CODE_W-1:0] code_word;
    } mft_cmd_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
        logic frame_end;
    } mft_res_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] half_bit_ticks;
        logic [CFG_DATA_W-1:0] header_ticks;
        logic [CFG_DATA_W-1:0] gap_ticks;
    } mft_cfg_t;

endpackage

/* design/mft_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mft_cfg_regs
// Configuration register file: three timing registers written by index.
// ----------------------------------------------------------------------------
module mft_cfg_regs
    import mft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output mft_cfg_t               cfg
);

    mft_cfg_t cfg_reg;
    mft_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_HALF_BIT: cfg_next.half_bit_ticks = wr_data;
                REG_HEADER:   cfg_next.header_ticks   = wr_data;
                REG_GAP:      cfg_next.gap_ticks      = wr_data;
                default:      cfg_next = cfg_reg; // unknown index: ignore
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks <= RST_HALF_BIT;
            cfg_reg.header_ticks   <= RST_HEADER;
            cfg_reg.gap_ticks      <= RST_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/mft_engine.sv */
// ----------------------------------------------------------------------------
// mft_engine
// Frame sequencer: phase, shift word, bit and tick counters, advanced once
// per accepted transaction; produces the result of that transaction.
// ----------------------------------------------------------------------------
module mft_engine
    import mft_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  mft_cmd_t cmd,
    input  mft_cfg_t cfg,
    output mft_res_t res
);

    localparam int unsigned BCNT_W = $clog2(WORD_BITS + 1);
    localparam logic [BCNT_W-1:0] LAST_BIT = BCNT_W'(WORD_BITS);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BITS   = 2'd2;
    localparam logic [1:0] PH_GAP    = 2'd3;

    logic [1:0]            phase_reg,       phase_next;
    logic [WORD_BITS-1:0]  shift_word_reg,  shift_word_next;
    logic [BCNT_W-1:0]     bits_sent_reg,   bits_sent_next;
    logic                  second_half_reg, second_half_next;
    logic [CFG_DATA_W-1:0] tick_count_reg,  tick_count_next;

    logic [63:0]           word_ext;
    logic [CFG_DATA_W-1:0] tick_dec;
    logic [BCNT_W-1:0]     bits_inc;
    logic                  rejected;
    logic                  frame_end;

    // A register holding zero still gives a one-tick segment
    function automatic logic [CFG_DATA_W-1:0] load_of(input logic [CFG_DATA_W-1:0] v);
        load_of = (v == '0) ? CFG_DATA_W'(1) : v;
    endfunction

    assign word_ext = 64'(cmd.code_word);
    assign tick_dec = tick_count_reg - CFG_DATA_W'(1);
    assign bits_inc = bits_sent_reg + BCNT_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        shift_word_next  = shift_word_reg;
        bits_sent_next   = bits_sent_reg;
        second_half_next = second_half_reg;
        tick_count_next  = tick_count_reg;
        rejected         = 1'b0;
        frame_end        = 1'b0;

        if (cmd.command)
        begin
            if (phase_reg == PH_IDLE)
            begin
                shift_word_next  = word_ext[WORD_BITS-1:0];
                bits_sent_next   = '0;
                second_half_next = 1'b0;
                tick_count_next  = load_of(cfg.header_ticks);
                phase_next       = PH_HEADER;
            end
            else
            begin
                rejected = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_count_next = tick_dec;
            if (tick_dec == '0)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        phase_next       = PH_BITS;
                        bits_sent_next   = '0;
                        second_half_next = 1'b0;
                        tick_count_next  = load_of(cfg.half_bit_ticks);
                    end
                    PH_BITS:
                    begin
                        if (!second_half_reg)
                        begin
                            second_half_next = 1'b1;
                            tick_count_next  = load_of(cfg.half_bit_ticks);
                        end
                        else
                        begin
                            second_half_next = 1'b0;
                            shift_word_next  = shift_word_reg << 1;
                            bits_sent_next   = bits_inc;
                            if (bits_inc >= LAST_BIT)
                            begin
                                phase_next      = PH_GAP;
                                tick_count_next = load_of(cfg.gap_ticks);
                            end
                            else
                            begin
                                tick_count_next = load_of(cfg.half_bit_ticks);
                            end
                        end
                    end
                    default: // gap over: free the block
                    begin
                        phase_next       = PH_IDLE;
                        bits_sent_next   = '0;
                        second_half_next = 1'b0;
                        frame_end        = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.rejected  = rejected;
        res.frame_end = frame_end;
        res.busy_res  = (phase_next != PH_IDLE);
        case (phase_next)
            PH_HEADER: res.line_level = 1'b1;
            PH_BITS:   res.line_level = shift_word_next[WORD_BITS-1] ^ second_half_next;
            default:   res.line_level = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            shift_word_reg  <= '0;
            bits_sent_reg   <= '0;
            second_half_reg <= 1'b0;
            tick_count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            shift_word_reg  <= shift_word_next;
            bits_sent_reg   <= bits_sent_next;
            second_half_reg <= second_half_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    // A running segment never sits at zero ticks
    a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tick_count_reg != '0))
        else $error("segment running with zero ticks left");

    // Idle leaves the bit position cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bits_sent_reg == '0 && !second_half_reg))
        else $error("bit position not cleared while idle");

    // The gap only follows the full word
    a_gap_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_GAP) |-> (bits_sent_reg == LAST_BIT && !second_half_reg))
        else $error("gap entered before the last bit");

    // The bit counter never runs past the word
    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_sent_reg <= LAST_BIT)
        else $error("bit counter beyond word width");

endmodule

/* design/manchester_frame_transmitter.sv */
// ----------------------------------------------------------------------------
// manchester_frame_transmitter
// Manchester-coded frame sender: header, MSB-first word and gap, paced by tick
// transactions, with a result register towards the consumer.
// ----------------------------------------------------------------------------
// Result: registered; valid in the cycle after its command transaction is taken.
// Throughput: one transaction per cycle unless a waiting result is not taken; the
// single result register is refilled in the same cycle that the consumer takes it.
// Reset: asynchronous, active low; clears the frame state to idle, empties the
// result register and loads the timing registers with 3, 6 and 40 ticks.
// ----------------------------------------------------------------------------
module manchester_frame_transmitter
    import mft_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  mft_cmd_t               cmd_data,
    // result channel
    output logic                   res_valid,
    input  logic                   res_ready,
    output mft_res_t               res_data,
    // configuration write port
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    mft_cfg_t cfg;
    mft_res_t step_res;
    mft_res_t res_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    logic     step;

    // Take a new transaction whenever the result register is empty or is
    // being drained in this cycle; the engine advances only on a take.
    assign cmd_ready      = !res_valid_reg || res_ready;
    assign step           = cmd_valid && cmd_ready;
    assign res_valid_next = step || (res_valid_reg && !res_ready);

    mft_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Sequencer: every tick or send request yields exactly one result
    mft_engine #(
        .WORD_BITS (WORD_BITS)
    ) u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_data),
        .cfg   (cfg),
        .res   (step_res)
    );

    // Result register: hold until taken, reload on each new transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Every taken command leaves a result waiting in the next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("command taken without a result");

    // A dropped send request never coincides with the end of a frame
    a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.rejected) |-> (!res_reg.frame_end && res_reg.busy_res))
        else $error("rejected result marks frame end or idle");

    // Frame end reports the line free and low
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.frame_end) |-> (!res_reg.busy_res && !res_reg.line_level))
        else $error("frame end while line still busy");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Manchester frame transmitter. Tick and send
// commands go in over the command channel; every result is checked against a
// cycle-free model of the frame sequencer (header, MSB-first Manchester bits,
// gap). The bench also exercises dropped sends, zero timing registers, long
// segments, random idling on both channels, and a long consumer stall.
// ----------------------------------------------------------------------------
module tb
    import mft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_BITS      = 32;
    localparam time         CLK_PERIOD     = 12ns;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 50;
    localparam int unsigned STALL_CYCLES   = 400;

    // Index past the end of the register list; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BITS,
        PH_GAP
    } frame_phase_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cmd_valid;
    logic                   cmd_ready;
    mft_cmd_t               cmd_data;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    mft_res_t               res_data;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    always #(CLK_PERIOD / 2) clk = ~clk;

    manchester_frame_transmitter #(
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // ------------------------------------------------------------------------
    // Model state: a private copy of the timing registers and the sequencer
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] m_half_bit;
    logic [CFG_DATA_W-1:0] m_header;
    logic [CFG_DATA_W-1:0] m_gap;
    frame_phase_t          m_phase;
    logic [WORD_BITS-1:0]  m_shift;
    int unsigned           m_bits_sent;
    logic                  m_second_half;
    logic [15:0]           m_ticks_left;

    // Results still owed by the block, oldest first
    mft_res_t expected_line[$];

    // Idling controls shared by the stimulus and the consumer
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned stall_requests = 0;
    int unsigned stalls_started = 0;
    int unsigned stall_left     = 0;

    // Bookkeeping
    int unsigned error_count   = 0;
    int unsigned items_counted = 0;
    int unsigned frames_ended  = 0;
    int unsigned sends_dropped = 0;
    int unsigned reg_writes    = 0;
    int unsigned quiet_cycles  = 0;

    // ------------------------------------------------------------------------
    // Model of the sequencer
    // ------------------------------------------------------------------------

    // A register holding zero is loaded as one, so no segment is empty
    function automatic logic [15:0] tick_load(input logic [CFG_DATA_W-1:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    // Advance the model by one command and return the result it causes
    function automatic mft_res_t frame_step(input mft_cmd_t item);
        mft_res_t res;
        res = '0;
        if (item.command)
        begin
            if (m_phase == PH_IDLE)
            begin
                // Load the word; no time passes on a send
                m_shift       = WORD_BITS'(item.code_word);
                m_bits_sent   = 0;
                m_second_half = 1'b0;
                m_ticks_left  = tick_load(m_header);
                m_phase       = PH_HEADER;
            end
            else
            begin
                res.rejected = 1'b1;
            end
        end
        else if (m_phase != PH_IDLE)
        begin
            m_ticks_left = m_ticks_left - 16'd1;
            if (m_ticks_left == '0)
            begin
                case (m_phase)
                    PH_HEADER:
                    begin
                        m_phase       = PH_BITS;
                        m_bits_sent   = 0;
                        m_second_half = 1'b0;
                        m_ticks_left  = tick_load(m_half_bit);
                    end
                    PH_BITS:
                    begin
                        if (!m_second_half)
                        begin
                            m_second_half = 1'b1;
                            m_ticks_left  = tick_load(m_half_bit);
                        end
                        else
                        begin
                            m_second_half = 1'b0;
                            m_shift       = m_shift << 1;
                            m_bits_sent++;
                            if (m_bits_sent >= WORD_BITS)
                            begin
                                m_phase      = PH_GAP;
                                m_ticks_left = tick_load(m_gap);
                            end
                            else
                            begin
                                m_ticks_left = tick_load(m_half_bit);
                            end
                        end
                    end
                    default:
                    begin
                        m_phase       = PH_IDLE;
                        m_bits_sent   = 0;
                        m_second_half = 1'b0;
                        res.frame_end = 1'b1;
                    end
                endcase
            end
        end
        // Header drives high; bit halves follow the code; idle and gap are low
        if (m_phase == PH_HEADER)
            res.line_level = 1'b1;
        else if (m_phase == PH_BITS)
            res.line_level = m_shift[WORD_BITS-1] ^ m_second_half;
        else
            res.line_level = 1'b0;
        res.busy_res = (m_phase != PH_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("tb: mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Command side: one transaction per call; valid stays high after the
    // handshake so that a following command goes out without a bubble
    // ------------------------------------------------------------------------
    task automatic send_command(input logic cmd, input logic [CODE_W-1:0] word);
        mft_cmd_t item;
        mft_res_t want;
        item.command   = cmd;
        item.code_word = word;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        @(posedge clk);
        while (cmd_ready !== 1'b1)
            @(posedge clk);
        // Ticks while idle change nothing and are not counted
        if (cmd || m_phase != PH_IDLE)
            items_counted++;
        want = frame_step(item);
        if (want.rejected)
            sends_dropped++;
        if (want.frame_end)
            frames_ended++;
        expected_line.push_back(want);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_line.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write one timing register; call only once the block has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_HALF_BIT: m_half_bit = val;
            REG_HEADER:   m_header   = val;
            REG_GAP:      m_gap      = val;
            default:      ;
        endcase
        reg_writes++;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Send one word and tick until the frame has ended; some sends are
    // slipped in while busy and must be dropped
    task automatic run_frame(input logic [CODE_W-1:0] word, input int unsigned reject_pct);
        send_command(1'b1, word);
        while (m_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < reject_pct)
                send_command(1'b1, $urandom);
            else
                send_command(1'b0, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready, with a counted stall when asked for
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_requests != stalls_started)
        begin
            res_ready      <= 1'b0;
            stall_left     <= STALL_CYCLES;
            stalls_started <= stalls_started + 1;
        end
        else if (stall_left > 0)
        begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest expectation, field by field
    always @(posedge clk)
    begin : check_results
        mft_res_t want;
        if (res_valid === 1'b1 && res_ready === 1'b1)
        begin
            if (expected_line.size() == 0)
            begin
                report_error($sformatf("result %b with nothing expected", res_data));
            end
            else
            begin
                want = expected_line.pop_front();
                if (res_data.line_level !== want.line_level)
                    report_error($sformatf("line_level %b, expected %b",
                                           res_data.line_level, want.line_level));
                if (res_data.busy_res !== want.busy_res)
                    report_error($sformatf("busy_res %b, expected %b",
                                           res_data.busy_res, want.busy_res));
                if (res_data.rejected !== want.rejected)
                    report_error($sformatf("rejected %b, expected %b",
                                           res_data.rejected, want.rejected));
                if (res_data.frame_end !== want.frame_end)
                    report_error($sformatf("frame_end %b, expected %b",
                                           res_data.frame_end, want.frame_end));
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((cmd_valid === 1'b1 && cmd_ready === 1'b1) ||
            (res_valid === 1'b1 && res_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: watchdog expired after %0d cycles without a transaction",
                     quiet_cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks while idle, then one frame with the reset timing
    task automatic test_reset_timing();
        repeat (3) send_command(1'b0, $urandom);
        run_frame(32'hA5C3_0F96, 0);
        repeat (2) send_command(1'b0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Drop two sends in a row, then one at the start of every busy phase
    task automatic test_busy_requests();
        frame_phase_t seen;
        write_reg(REG_HALF_BIT, 16'd2);
        write_reg(REG_HEADER, 16'd2);
        write_reg(REG_GAP, 16'd2);
        seen = PH_IDLE;
        send_command(1'b1, 32'h8000_0001);
        send_command(1'b1, 32'h0000_0000);
        send_command(1'b1, 32'hFFFF_FFFF);
        while (m_phase != PH_IDLE)
        begin
            if (m_phase != seen)
            begin
                seen = m_phase;
                send_command(1'b1, $urandom);
            end
            send_command(1'b0, $urandom);
        end
        drain();
    endtask

    // Zero in every register must behave as one tick per segment
    task automatic test_zero_registers();
        write_reg(REG_HALF_BIT, 16'd0);
        write_reg(REG_HEADER, 16'd0);
        write_reg(REG_GAP, 16'd0);
        run_frame(32'hFFFF_FFFF, 0);
        run_frame(32'h0000_0000, 0);
        drain();
    endtask

    // A write past the register list must leave the timing alone
    task automatic test_unused_index();
        write_reg(REG_HALF_BIT, 16'd1);
        write_reg(REG_HEADER, 16'd1);
        write_reg(REG_GAP, 16'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        run_frame(32'h5555_AAAA, 0);
        drain();
    endtask

    // Long header, then long gap; keep the bits short
    task automatic test_long_segments();
        write_reg(REG_HALF_BIT, 16'd1);
        write_reg(REG_HEADER, 16'd60);
        write_reg(REG_GAP, 16'd1);
        run_frame($urandom, 0);
        drain();
        write_reg(REG_HEADER, 16'd1);
        write_reg(REG_GAP, 16'd60);
        run_frame($urandom, 0);
        drain();
    endtask

    // Wide half bits, sized to keep the run short
    task automatic test_slow_bits();
        write_reg(REG_HALF_BIT, 16'd4);
        write_reg(REG_HEADER, 16'd2);
        write_reg(REG_GAP, 16'd3);
        run_frame(32'hC3A5_5A3C, 0);
        drain();
    endtask

    // Hold the consumer off while commands keep coming, so the block backs up
    task automatic test_back_pressure();
        write_reg(REG_HALF_BIT, 16'd1);
        write_reg(REG_HEADER, 16'd1);
        write_reg(REG_GAP, 16'd2);
        stall_requests++;
        run_frame($urandom, 10);
        drain();
    endtask

    // Mostly well-formed frames with random content and timing; idle ticks
    // between frames and stray sends inside them are the noise
    task automatic test_random_traffic(input int unsigned tx_idle,
                                       input int unsigned rx_idle,
                                       input int unsigned quota);
        int unsigned          start;
        int unsigned          frames_here;
        logic [CODE_W-1:0]    word;
        logic [CFG_DATA_W-1:0] timing [3];
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        start         = items_counted;
        frames_here   = 0;
        while (items_counted - start < quota)
        begin
            if (frames_here % 2 == 0)
            begin
                drain();
                foreach (timing[i])
                begin
                    case ($urandom_range(0, 19))
                        0:       timing[i] = 16'd0;
                        1, 2:    timing[i] = 16'($urandom_range(4, 12));
                        default: timing[i] = 16'($urandom_range(1, 3));
                    endcase
                end
                write_reg(REG_HALF_BIT, timing[0]);
                write_reg(REG_HEADER, timing[1]);
                write_reg(REG_GAP, timing[2]);
            end
            repeat ($urandom_range(0, 3)) send_command(1'b0, $urandom);
            case ($urandom_range(0, 9))
                0:       word = 32'h0000_0000;
                1:       word = 32'hFFFF_FFFF;
                2:       word = {16{2'b10}};
                default: word = $urandom;
            endcase
            run_frame(word, 6);
            frames_here++;
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;

        m_half_bit    = RST_HALF_BIT;
        m_header      = RST_HEADER;
        m_gap         = RST_GAP;
        m_phase       = PH_IDLE;
        m_shift       = '0;
        m_bits_sent   = 0;
        m_second_half = 1'b0;
        m_ticks_left  = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames and the stall, with the sender idling less than
        // the receiver
        send_idle_pct = 34;
        recv_idle_pct = 66;
        test_reset_timing();
        test_busy_requests();
        test_zero_registers();
        test_unused_index();
        test_long_segments();
        test_slow_bits();
        test_back_pressure();

        test_random_traffic(34, 66, 150);
        test_random_traffic(66, 34, 150);
        test_random_traffic(0, 0, 150);

        // Let any stray result surface, then settle the books
        repeat (8) @(posedge clk);
        if (expected_line.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_line.size()));

        $display("tb: %0d counted commands, %0d frames completed, %0d sends dropped",
                 items_counted, frames_ended, sends_dropped);
        $display("tb: %0d register writes incl. zero, long and unused index; %0d errors",
                 reg_writes, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/mft_pkg.sv
design/mft_cfg_regs.sv
design/mft_engine.sv
design/manchester_frame_transmitter.sv
test/tb.sv
